[design/atmc_pkg.sv]
// ----------------------------------------------------------------------------
// atmc_pkg: shared types and constants for the altitude trellis min-cost unit
// Level count, cost widths, register indexes and the per-level state record.
// ----------------------------------------------------------------------------
package atmc_pkg;

    localparam int ALTITUDES = 10;
    localparam int COST_W    = 20;
    localparam int WIND_W    = 8;
    localparam int BASE_W    = 8;
    localparam int SUM_W     = COST_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_CLIMB = 2'd0;
    localparam cfg_idx_t REG_HOLD  = 2'd1;
    localparam cfg_idx_t REG_SINK  = 2'd2;

    localparam logic [BASE_W-1:0] CLIMB_RESET = 8'd60;
    localparam logic [BASE_W-1:0] HOLD_RESET  = 8'd30;
    localparam logic [BASE_W-1:0] SINK_RESET  = 8'd20;

    typedef logic signed [WIND_W-1:0] wind_t;

    typedef struct packed {
        logic                     reach;
        logic signed [COST_W-1:0] cost;
    } lvl_t;

    typedef struct packed {
        logic [BASE_W-1:0] climb;
        logic [BASE_W-1:0] hold;
        logic [BASE_W-1:0] sink;
    } base_t;

endpackage

[design/atmc_lane.sv]
// ----------------------------------------------------------------------------
// atmc_lane: one altitude level of the trellis
// Add-compare-select over hold, climb-in and sink-in, with saturation.
// ----------------------------------------------------------------------------
module atmc_lane (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           home,
    input  logic           step,
    input  logic           restart,
    input  atmc_pkg::base_t base,
    input  atmc_pkg::lvl_t  below,
    input  atmc_pkg::lvl_t  above,
    input  atmc_pkg::wind_t wind_below,
    input  atmc_pkg::wind_t wind_self,
    input  atmc_pkg::wind_t wind_above,
    output atmc_pkg::lvl_t  cur,
    output atmc_pkg::lvl_t  nxt
);
    import atmc_pkg::*;

    lvl_t state_reg;
    lvl_t state_next;

    logic signed [SUM_W-1:0] cand_hold;
    logic signed [SUM_W-1:0] cand_climb;
    logic signed [SUM_W-1:0] cand_sink;
    logic signed [SUM_W-1:0] best;
    logic                    have;
    logic signed [COST_W-1:0] clamped;

    // Cost of leaving a level is the move's base cost minus that level's wind.
    assign cand_hold  = SUM_W'(state_reg.cost) + SUM_W'($signed({1'b0, base.hold}))
                      - SUM_W'(wind_self);
    assign cand_climb = SUM_W'(below.cost) + SUM_W'($signed({1'b0, base.climb}))
                      - SUM_W'(wind_below);
    assign cand_sink  = SUM_W'(above.cost) + SUM_W'($signed({1'b0, base.sink}))
                      - SUM_W'(wind_above);

    always_comb
    begin
        have = 1'b0;
        best = '0;
        if (state_reg.reach)
        begin
            best = cand_hold;
            have = 1'b1;
        end
        if (below.reach && (!have || cand_climb < best))
        begin
            best = cand_climb;
        end
        have = have | below.reach;
        if (above.reach && (!have || cand_sink < best))
        begin
            best = cand_sink;
        end
        have = have | above.reach;

        if (best > SUM_W'(COST_MAX))
        begin
            clamped = COST_MAX;
        end
        else if (best < SUM_W'(COST_MIN))
        begin
            clamped = COST_MIN;
        end
        else
        begin
            clamped = best[COST_W-1:0];
        end
    end

    assign nxt.reach = have;
    assign nxt.cost  = have ? clamped : '0;

    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            if (restart)
            begin
                state_next.reach = home;
                state_next.cost  = '0;
            end
            else
            begin
                state_next = nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.reach <= home;
            state_reg.cost  <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cur = state_reg;

endmodule

[design/atmc_out.sv]
// ----------------------------------------------------------------------------
// atmc_out: result merge and output register
// Picks the level-zero cost at the end of a trip and holds it for the sink.
// ----------------------------------------------------------------------------
module atmc_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  atmc_pkg::lvl_t                 level0,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [atmc_pkg::COST_W-1:0] min_cost,
    output logic                           space
);
    import atmc_pkg::*;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [COST_W-1:0] min_cost_reg;
    logic signed [COST_W-1:0] min_cost_next;

    // The register may take a new beat in the cycle its old one leaves.
    assign space = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        min_cost_next  = min_cost_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            min_cost_next  = level0.reach ? level0.cost : COST_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_cost_reg <= min_cost_next;
    end

    assign out_valid = out_valid_reg;
    assign min_cost  = min_cost_reg;

endmodule

[design/altitude_trellis_min_cost_unit.sv]
// ----------------------------------------------------------------------------
// altitude_trellis_min_cost_unit: min-plus trellis over altitude levels
// One column per input beat; emits the level-zero cost on the last column.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_ready   | wind_level0..wind_level9, last_column
//  out     | out_valid / out_ready | min_cost
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One column per cycle while in_ready is high: each level lane does its
// add-compare-select on the registered costs in the cycle the beat is accepted.
// A last-column beat loads the output register and the result is valid from the
// next cycle; the path state returns to level zero at the same edge.
// in_ready drops only while the output register holds a beat that is not taken.
// Reset restores the cost registers and the path state; cfg is always ready.
module altitude_trellis_min_cost_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  atmc_pkg::wind_t                    wind_level0,
    input  atmc_pkg::wind_t                    wind_level1,
    input  atmc_pkg::wind_t                    wind_level2,
    input  atmc_pkg::wind_t                    wind_level3,
    input  atmc_pkg::wind_t                    wind_level4,
    input  atmc_pkg::wind_t                    wind_level5,
    input  atmc_pkg::wind_t                    wind_level6,
    input  atmc_pkg::wind_t                    wind_level7,
    input  atmc_pkg::wind_t                    wind_level8,
    input  atmc_pkg::wind_t                    wind_level9,
    input  logic                               last_column,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [atmc_pkg::COST_W-1:0] min_cost,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  atmc_pkg::cfg_idx_t                 cfg_index,
    input  logic [atmc_pkg::BASE_W-1:0]        cfg_data
);
    import atmc_pkg::*;

    base_t base_reg;
    base_t base_next;

    wind_t wind_pad [ALTITUDES+2];
    lvl_t  lvl_pad  [ALTITUDES+2];
    lvl_t  lane_cur [ALTITUDES];
    lvl_t  lane_nxt [ALTITUDES];

    logic step;
    logic space;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_next = base_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLIMB: base_next.climb = cfg_data;
                REG_HOLD:  base_next.hold  = cfg_data;
                REG_SINK:  base_next.sink  = cfg_data;
                default:   base_next = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg.climb <= CLIMB_RESET;
            base_reg.hold  <= HOLD_RESET;
            base_reg.sink  <= SINK_RESET;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign in_ready = space;
    assign step     = in_valid && in_ready;

    // Padded neighbor views: the slots past either end are never reachable.
    assign wind_pad[0]           = '0;
    assign wind_pad[1]           = wind_level0;
    assign wind_pad[2]           = wind_level1;
    assign wind_pad[3]           = wind_level2;
    assign wind_pad[4]           = wind_level3;
    assign wind_pad[5]           = wind_level4;
    assign wind_pad[6]           = wind_level5;
    assign wind_pad[7]           = wind_level6;
    assign wind_pad[8]           = wind_level7;
    assign wind_pad[9]           = wind_level8;
    assign wind_pad[10]          = wind_level9;
    assign wind_pad[ALTITUDES+1] = '0;
    assign lvl_pad[0]            = '0;
    assign lvl_pad[ALTITUDES+1]  = '0;

    for (genvar h = 0; h < ALTITUDES; h++)
    begin : g_lane
        assign lvl_pad[h+1] = lane_cur[h];

        atmc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .home       (h == 0),
            .step       (step),
            .restart    (last_column),
            .base       (base_reg),
            .below      (lvl_pad[h]),
            .above      (lvl_pad[h+2]),
            .wind_below (wind_pad[h]),
            .wind_self  (wind_pad[h+1]),
            .wind_above (wind_pad[h+2]),
            .cur        (lane_cur[h]),
            .nxt        (lane_nxt[h])
        );
    end

    atmc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && last_column),
        .level0    (lane_nxt[0]),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .min_cost  (min_cost),
        .space     (space)
    );

    a_level0_reach : assert property (@(posedge clk) disable iff (!rst_n)
        lane_cur[0].reach)
        else $error("level zero lost reachability");

    a_trip_restart : assert property (@(posedge clk) disable iff (!rst_n)
        step && last_column |=> lane_cur[0].reach && lane_cur[0].cost == '0
                                && !lane_cur[1].reach)
        else $error("path state not cleared after last column");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        step && last_column |=> out_valid)
        else $error("last column produced no result");

    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result register is blocked");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the altitude trellis min-cost unit
// Streams wind columns with bursty valid and a patterned output ready, updates
// its own min-plus trellis on every accepted column, and compares each trip
// cost with the value that the trellis predicts. The base costs change between
// phases, including both ends of their range.
// ----------------------------------------------------------------------------
module tb;
    import atmc_pkg::*;

    localparam int       CYCLE_LIMIT      = 400000;
    localparam int       LONG_HOLD_CYCLES = 300;
    localparam int       DRAIN_CYCLES     = 4;
    localparam cfg_idx_t REG_SPARE        = 2'd3;
    localparam wind_t    WIND_TOP         = 8'sh7f;
    localparam wind_t    WIND_BOTTOM      = 8'sh80;

    typedef enum {WIND_FULL, WIND_EXTREME, WIND_CALM} wind_style_t;

    typedef struct {
        wind_t wind [ALTITUDES];
        logic  last;
    } column_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    wind_t                    wind_bus [ALTITUDES] = '{default: '0};
    logic                     last_column = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [COST_W-1:0] min_cost;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index = REG_CLIMB;
    logic [BASE_W-1:0]        cfg_data = '0;

    column_t                  pending_columns [$];
    logic signed [COST_W-1:0] expected_min_costs [$];
    int                       error_count = 0;
    int                       cycle_count = 0;
    int                       long_hold_req = 0;

    // Trellis state kept by the bench.
    logic [BASE_W-1:0]        climb_base;
    logic [BASE_W-1:0]        hold_base;
    logic [BASE_W-1:0]        sink_base;
    logic signed [COST_W-1:0] path_cost [ALTITUDES];
    logic [ALTITUDES-1:0]     path_reach;

    altitude_trellis_min_cost_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .wind_level0 (wind_bus[0]),
        .wind_level1 (wind_bus[1]),
        .wind_level2 (wind_bus[2]),
        .wind_level3 (wind_bus[3]),
        .wind_level4 (wind_bus[4]),
        .wind_level5 (wind_bus[5]),
        .wind_level6 (wind_bus[6]),
        .wind_level7 (wind_bus[7]),
        .wind_level8 (wind_bus[8]),
        .wind_level9 (wind_bus[9]),
        .last_column (last_column),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .min_cost    (min_cost),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic clear_path();
        for (int h = 0; h < ALTITUDES; h++)
        begin
            path_cost[h] = '0;
        end
        path_reach = 1;
    endtask

    // One add-compare-select column on the beat currently on the input bus.
    task automatic advance_trellis();
        int                       best;
        int                       cand;
        bit                       have;
        int                       next_cost [ALTITUDES];
        logic [ALTITUDES-1:0]     next_reach;
        logic signed [COST_W-1:0] trip_cost;
        next_reach = '0;
        for (int h = 0; h < ALTITUDES; h++)
        begin
            have = 1'b0;
            best = 0;
            if (path_reach[h])
            begin
                best = int'(path_cost[h]) + int'(hold_base) - int'(wind_bus[h]);
                have = 1'b1;
            end
            if (h >= 1 && path_reach[h-1])
            begin
                cand = int'(path_cost[h-1]) + int'(climb_base) - int'(wind_bus[h-1]);
                if (!have || cand < best)
                    best = cand;
                have = 1'b1;
            end
            if (h + 1 < ALTITUDES && path_reach[h+1])
            begin
                cand = int'(path_cost[h+1]) + int'(sink_base) - int'(wind_bus[h+1]);
                if (!have || cand < best)
                    best = cand;
                have = 1'b1;
            end
            if (have)
            begin
                if (best > int'(COST_MAX))
                    best = int'(COST_MAX);
                else if (best < int'(COST_MIN))
                    best = int'(COST_MIN);
                next_reach[h] = 1'b1;
            end
            next_cost[h] = best;
        end
        for (int h = 0; h < ALTITUDES; h++)
        begin
            path_cost[h] = COST_W'(next_cost[h]);
        end
        path_reach = next_reach;
        if (last_column)
        begin
            trip_cost = path_reach[0] ? path_cost[0] : COST_MAX;
            expected_min_costs.insert(expected_min_costs.size(), trip_cost);
            clear_path();
        end
    endtask

    // Result check first, then the column that lands at this edge, then any
    // base cost write, which only takes effect for later columns.
    always @(posedge clk)
    begin : result_mon
        logic signed [COST_W-1:0] want;
        if (!rst_n)
        begin
            climb_base = CLIMB_RESET;
            hold_base  = HOLD_RESET;
            sink_base  = SINK_RESET;
            clear_path();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_min_costs.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual min_cost %0d",
                             $time, min_cost);
                    error_count++;
                end
                else
                begin
                    want = expected_min_costs.pop_front();
                    if (min_cost !== want)
                    begin
                        $display("%0t: min_cost mismatch, expected %0d, actual %0d",
                                 $time, want, min_cost);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                advance_trellis();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CLIMB: climb_base = cfg_data;
                    REG_HOLD:  hold_base  = cfg_data;
                    REG_SINK:  sink_base  = cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // Column source: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : column_src
        column_t col;
        int      burst_left;
        int      gap_left;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            last_column <= 1'b0;
            for (int h = 0; h < ALTITUDES; h++)
            begin
                wind_bus[h] <= '0;
            end
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_columns.size() != 0)
            begin
                col = pending_columns.pop_front();
                for (int h = 0; h < ALTITUDES; h++)
                begin
                    wind_bus[h] <= col.wind[h];
                end
                last_column <= col.last;
                in_valid    <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output ready cycles through four stall patterns; a hold request from the
    // stimulus overrides them for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin : ready_pattern
        logic [9:0] rx_tick;
        int         long_hold_seen;
        int         long_hold_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_tick        = '0;
            long_hold_seen = 0;
            long_hold_left = 0;
        end
        else
        begin
            rx_tick++;
            if (long_hold_req != long_hold_seen)
            begin
                long_hold_seen = long_hold_req;
                long_hold_left = LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (long_hold_left != 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_tick[9:8])
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
                    2'd2:    out_ready <= (rx_tick[1:0] == 2'd0);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_trip(input int len, input wind_style_t style);
        column_t col;
        for (int c = 0; c < len; c++)
        begin
            for (int h = 0; h < ALTITUDES; h++)
            begin
                case (style)
                    WIND_FULL:    col.wind[h] = wind_t'($urandom_range(0, 255));
                    WIND_EXTREME: col.wind[h] = ($urandom_range(0, 1) == 1) ? WIND_TOP
                                                                            : WIND_BOTTOM;
                    default:      col.wind[h] = wind_t'(int'($urandom_range(0, 8)) - 4);
                endcase
            end
            col.last = (c == len - 1);
            pending_columns.insert(pending_columns.size(), col);
        end
    endtask

    task automatic queue_flat_trip(input int len, input wind_t w);
        column_t col;
        for (int c = 0; c < len; c++)
        begin
            for (int h = 0; h < ALTITUDES; h++)
            begin
                col.wind[h] = w;
            end
            col.last = (c == len - 1);
            pending_columns.insert(pending_columns.size(), col);
        end
    endtask

    // Checkerboard of full tailwind and full headwind, shifting every column.
    task automatic queue_checker_trip(input int len);
        column_t col;
        for (int c = 0; c < len; c++)
        begin
            for (int h = 0; h < ALTITUDES; h++)
            begin
                col.wind[h] = ((h + c) % 2 == 0) ? WIND_TOP : WIND_BOTTOM;
            end
            col.last = (c == len - 1);
            pending_columns.insert(pending_columns.size(), col);
        end
    endtask

    task automatic run_random_trips(input int n_columns, input int max_len);
        int          queued;
        int          len;
        int          pick;
        wind_style_t style;
        queued = 0;
        while (queued < n_columns)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = 1;
            else if (pick < 75)
                len = $urandom_range(1, (max_len < 12) ? max_len : 12);
            else
                len = $urandom_range(1, max_len);
            pick = $urandom_range(0, 9);
            style = (pick == 0) ? WIND_EXTREME : (pick == 1) ? WIND_CALM : WIND_FULL;
            queue_trip(len, style);
            queued += len;
        end
    endtask

    // Waits until every column is in and every trip cost has come out.
    task automatic wait_idle();
        while (pending_columns.size() != 0 || in_valid || expected_min_costs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input cfg_idx_t idx, input logic [BASE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_bases(input logic [BASE_W-1:0] climb, input logic [BASE_W-1:0] hold,
                               input logic [BASE_W-1:0] sink);
        wait_idle();
        write_base(REG_CLIMB, climb);
        write_base(REG_HOLD, hold);
        write_base(REG_SINK, sink);
        // The spare index must leave the base costs alone.
        write_base(REG_SPARE, BASE_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [BASE_W-1:0] settings [8][3];
        settings = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                     '{8'd0, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd255},
                     '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd0},
                     '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}};
        for (int s = 5; s < 8; s++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                settings[s][r] = BASE_W'($urandom_range(0, 255));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset base costs: single-column trips at both wind extremes, a
        // checkerboard long enough to reach the top level, and an extreme trip.
        queue_flat_trip(1, WIND_TOP);
        queue_flat_trip(1, WIND_BOTTOM);
        queue_checker_trip(12);
        queue_trip(11, WIND_EXTREME);
        wait_idle();

        for (int s = 0; s < 8; s++)
        begin
            apply_bases(settings[s][0], settings[s][1], settings[s][2]);
            run_random_trips(120, 40);
        end

        // Output held off while short trips keep arriving, so the unit backs up.
        apply_bases(BASE_W'($urandom_range(0, 255)), BASE_W'($urandom_range(0, 255)),
                    BASE_W'($urandom_range(0, 255)));
        long_hold_req = long_hold_req + 1;
        run_random_trips(80, 2);
        wait_idle();

        if (error_count == 0 && expected_min_costs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
design/atmc_pkg.sv
design/atmc_lane.sv
design/atmc_out.sv
design/altitude_trellis_min_cost_unit.sv
test/tb.sv
